>>> design/somsup_pkg.sv
// Shared types and constants for the sensorless observer mode supervisor.
// Holds the mode encoding, configuration register indexes and the result word layout.
package somsup_pkg;

    typedef enum logic [1:0] {
        MODE_VF  = 2'd0,
        MODE_POL = 2'd1,
        MODE_HFI = 2'd2,
        MODE_SMO = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_STARTUP_MODE  = 3'd0,
        CFG_UP_SPEED      = 3'd1,
        CFG_DOWN_SPEED    = 3'd2,
        CFG_ANGLE_LIMIT   = 3'd3,
        CFG_AGREE_TICKS   = 3'd4,
        CFG_DIR_MIN_SPEED = 3'd5,
        CFG_IQ_LIMIT      = 3'd6
    } t_cfg_idx;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 12;

    localparam logic [CNT_W-1:0] CNT_MAX    = 12'hFFF;
    localparam logic [1:0]       DOWN_TICKS = 2'd2;

    localparam logic             RST_STARTUP_MODE  = 1'b1;
    localparam logic [14:0]      RST_UP_SPEED      = 15'd300;
    localparam logic [14:0]      RST_DOWN_SPEED    = 15'd200;
    localparam logic [15:0]      RST_ANGLE_LIMIT   = 16'd7035;
    localparam logic [CNT_W-1:0] RST_AGREE_TICKS   = 12'd1000;
    localparam logic [14:0]      RST_DIR_MIN_SPEED = 15'd1000;
    localparam logic [14:0]      RST_IQ_LIMIT      = 15'd16000;

    typedef struct packed {
        logic  fault_now;
        logic  speed_fault;
        logic  clear_smo;
        logic  clear_hfi;
        logic  clear_id_sums;
        logic  flip_angle;
        logic  polarity_pi;
        t_mode mode;
    } t_result;

    localparam int RES_BITS = $bits(t_result);
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

endpackage

>>> design/sensorless_observer_mode_supervisor.sv
// Top level of the sensorless observer mode supervisor: input word register, tick logic,
// mode and counter state, result register. Depends on somsup_pkg.
//
// One control tick is taken per clock cycle when the output side keeps up. A word accepted
// is held in the input register until the tick advances, which writes its result word into
// the output register; the tick logic sits between the input register and the result register
// and updates the mode, counter and fault state in the same cycle, so the state update keeps
// up with the rate of one word per cycle.
module sensorless_observer_mode_supervisor #(
    parameter int ANGLE_BITS = 16,
    parameter int SPEED_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [somsup_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [somsup_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // Fields from bit 0 up: restart, mech_speed, hfi_speed, target_speed, smo_angle,
    // hfi_angle, polarity_ready, id_sum_pos, id_sum_neg, iq_current, zero fill.
    input  logic [((98+2*SPEED_BITS+2*ANGLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // Fields from bit 0 up: mode, polarity_pi, flip_angle, clear_id_sums, clear_hfi,
    // clear_smo, speed_fault, fault_now, zero fill.
    output logic [somsup_pkg::RES_W-1:0]            o_m_axis_tdata
);
    import somsup_pkg::*;

    localparam int OFS_MECH    = 1;
    localparam int OFS_HFI_SPD = OFS_MECH + SPEED_BITS;
    localparam int OFS_TGT     = OFS_HFI_SPD + SPEED_BITS;
    localparam int OFS_SMO_ANG = OFS_TGT + 16;
    localparam int OFS_HFI_ANG = OFS_SMO_ANG + ANGLE_BITS;
    localparam int OFS_POL_RDY = OFS_HFI_ANG + ANGLE_BITS;
    localparam int OFS_ID_POS  = OFS_POL_RDY + 1;
    localparam int OFS_ID_NEG  = OFS_ID_POS + 32;
    localparam int OFS_IQ      = OFS_ID_NEG + 32;
    localparam int IN_BITS     = OFS_IQ + 16;
    localparam int SW          = (SPEED_BITS > 15) ? SPEED_BITS : 15;
    localparam int DW          = (ANGLE_BITS + 1 > 16) ? ANGLE_BITS + 1 : 16;

    logic                  r_startup_mode;
    logic [14:0]           r_up_speed;
    logic [14:0]           r_down_speed;
    logic [15:0]           r_angle_limit;
    logic [CNT_W-1:0]      r_agree_ticks;
    logic [14:0]           r_dir_min_speed;
    logic [14:0]           r_iq_limit;

    logic                  r_in_valid;
    logic [IN_BITS-1:0]    r_in_data;
    logic                  r_out_valid;
    t_result               r_res;
    t_result               n_res;

    t_mode                 r_mode;
    t_mode                 n_mode;
    logic [CNT_W-1:0]      r_up_cnt;
    logic [CNT_W-1:0]      n_up_cnt;
    logic [1:0]            r_dn_cnt;
    logic [1:0]            n_dn_cnt;
    logic [CNT_W-1:0]      r_dir_cnt;
    logic [CNT_W-1:0]      n_dir_cnt;
    logic                  r_pol;
    logic                  n_pol;
    logic                  r_fault;
    logic                  n_fault;

    logic                  s_adv;
    logic                  in_restart;
    logic [SPEED_BITS-1:0] in_mech;
    logic [SPEED_BITS-1:0] in_hfi_spd;
    logic [15:0]           in_tgt;
    logic [ANGLE_BITS-1:0] in_smo_ang;
    logic [ANGLE_BITS-1:0] in_hfi_ang;
    logic                  in_pol_rdy;
    logic signed [31:0]    in_id_pos;
    logic signed [31:0]    in_id_neg;
    logic [15:0]           in_iq;

    logic [SPEED_BITS-1:0] spd_mag;
    logic [SW-1:0]         spd;
    logic                  hfi_neg;
    logic                  tgt_neg;
    logic [ANGLE_BITS-1:0] ang_d;
    logic [ANGLE_BITS:0]   ang_e;
    logic [ANGLE_BITS:0]   ang_dist;
    logic                  agree;
    logic [15:0]           iq_mag;
    logic                  fnow;
    logic [CNT_W-1:0]      dir_inc;
    logic [CNT_W-1:0]      up_tmp;
    logic [1:0]            dn_tmp;

    assign s_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || s_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(RES_W-RES_BITS){1'b0}}, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_mode  <= RST_STARTUP_MODE;
            r_up_speed      <= RST_UP_SPEED;
            r_down_speed    <= RST_DOWN_SPEED;
            r_angle_limit   <= RST_ANGLE_LIMIT;
            r_agree_ticks   <= RST_AGREE_TICKS;
            r_dir_min_speed <= RST_DIR_MIN_SPEED;
            r_iq_limit      <= RST_IQ_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_STARTUP_MODE:  r_startup_mode  <= i_cfg_data[0];
                CFG_UP_SPEED:      r_up_speed      <= i_cfg_data[14:0];
                CFG_DOWN_SPEED:    r_down_speed    <= i_cfg_data[14:0];
                CFG_ANGLE_LIMIT:   r_angle_limit   <= i_cfg_data[15:0];
                CFG_AGREE_TICKS:   r_agree_ticks   <= i_cfg_data[CNT_W-1:0];
                CFG_DIR_MIN_SPEED: r_dir_min_speed <= i_cfg_data[14:0];
                CFG_IQ_LIMIT:      r_iq_limit      <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (s_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_data <= i_s_axis_tdata[IN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_POL;
            r_up_cnt  <= '0;
            r_dn_cnt  <= '0;
            r_dir_cnt <= '0;
            r_pol     <= 1'b0;
            r_fault   <= 1'b0;
        end else if (s_adv) begin
            r_mode    <= n_mode;
            r_up_cnt  <= n_up_cnt;
            r_dn_cnt  <= n_dn_cnt;
            r_dir_cnt <= n_dir_cnt;
            r_pol     <= n_pol;
            r_fault   <= n_fault;
        end
    end

    assign in_restart = r_in_data[0];
    assign in_mech    = r_in_data[OFS_MECH +: SPEED_BITS];
    assign in_hfi_spd = r_in_data[OFS_HFI_SPD +: SPEED_BITS];
    assign in_tgt     = r_in_data[OFS_TGT +: 16];
    assign in_smo_ang = r_in_data[OFS_SMO_ANG +: ANGLE_BITS];
    assign in_hfi_ang = r_in_data[OFS_HFI_ANG +: ANGLE_BITS];
    assign in_pol_rdy = r_in_data[OFS_POL_RDY];
    assign in_id_pos  = r_in_data[OFS_ID_POS +: 32];
    assign in_id_neg  = r_in_data[OFS_ID_NEG +: 32];
    assign in_iq      = r_in_data[OFS_IQ +: 16];

    assign spd_mag  = in_mech[SPEED_BITS-1] ? (~in_mech + 1'b1) : in_mech;
    assign spd      = SW'(spd_mag);
    assign hfi_neg  = in_hfi_spd[SPEED_BITS-1];
    assign tgt_neg  = in_tgt[15];
    assign ang_d    = in_smo_ang - in_hfi_ang;
    assign ang_e    = {1'b1, {ANGLE_BITS{1'b0}}} - (ANGLE_BITS+1)'(ang_d);
    assign ang_dist = ((ANGLE_BITS+1)'(ang_d) < ang_e) ? (ANGLE_BITS+1)'(ang_d) : ang_e;
    assign agree    = DW'(ang_dist) <= DW'(r_angle_limit);
    assign iq_mag   = in_iq[15] ? (~in_iq + 1'b1) : in_iq;
    assign fnow     = (r_mode == MODE_SMO) && (iq_mag > 16'(r_iq_limit));
    assign dir_inc  = (r_dir_cnt == CNT_MAX) ? r_dir_cnt : r_dir_cnt + 1'b1;
    assign dn_tmp   = r_dn_cnt + 1'b1;

    always_comb begin
        if (agree) begin
            up_tmp = (r_up_cnt == CNT_MAX) ? r_up_cnt : r_up_cnt + 1'b1;
        end else if (r_up_cnt != '0) begin
            up_tmp = r_up_cnt - 1'b1;
        end else begin
            up_tmp = r_up_cnt;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_up_cnt  = r_up_cnt;
        n_dn_cnt  = r_dn_cnt;
        n_dir_cnt = r_dir_cnt;
        n_pol     = r_pol;
        n_fault   = r_fault;
        n_res     = '0;

        if (in_restart) begin
            n_mode    = r_startup_mode ? MODE_POL : MODE_VF;
            n_up_cnt  = '0;
            n_dn_cnt  = '0;
            n_dir_cnt = '0;
            n_fault   = 1'b0;
        end else begin
            n_res.fault_now = fnow;

            if ((r_mode == MODE_POL || r_mode == MODE_HFI)
                && spd >= SW'(r_dir_min_speed)) begin
                if (hfi_neg != tgt_neg) begin
                    if (!agree) begin
                        if (dir_inc > r_agree_ticks) begin
                            n_dir_cnt = '0;
                            n_pol     = 1'b1;
                        end else begin
                            n_dir_cnt = dir_inc;
                        end
                    end else if (r_dir_cnt != '0) begin
                        n_dir_cnt = r_dir_cnt - 1'b1;
                    end
                end else begin
                    n_dir_cnt = '0;
                end
            end

            case (r_mode)
                MODE_POL: begin
                    if (in_pol_rdy) begin
                        if (in_id_pos > in_id_neg) begin
                            n_pol = 1'b0;
                        end else begin
                            n_pol            = 1'b1;
                            n_res.flip_angle = 1'b1;
                        end
                        n_res.clear_id_sums = 1'b1;
                        n_mode              = MODE_HFI;
                    end
                end
                MODE_VF, MODE_HFI: begin
                    if (spd > SW'(r_up_speed)) begin
                        n_up_cnt = up_tmp;
                        if (up_tmp > r_agree_ticks && agree) begin
                            n_res.clear_hfi = (r_mode == MODE_HFI);
                            n_mode          = MODE_SMO;
                            n_up_cnt        = '0;
                        end
                    end else begin
                        n_dn_cnt = '0;
                        n_up_cnt = '0;
                    end
                end
                default: begin
                    if (spd < SW'(r_down_speed)) begin
                        n_dn_cnt = dn_tmp;
                        if (dn_tmp > DOWN_TICKS) begin
                            n_dn_cnt = '0;
                            if (!r_startup_mode) begin
                                n_mode = MODE_VF;
                            end else begin
                                n_mode          = MODE_HFI;
                                n_res.clear_smo = 1'b1;
                            end
                        end
                    end else begin
                        n_dn_cnt = '0;
                        n_up_cnt = '0;
                    end
                end
            endcase

            if (r_mode == MODE_SMO && n_mode != MODE_SMO) begin
                n_fault = 1'b0;
            end else if (fnow) begin
                n_fault = 1'b1;
            end
        end

        n_res.mode        = n_mode;
        n_res.polarity_pi = n_pol;
        n_res.speed_fault = n_fault;
    end

    a_mode_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> (r_res.mode == r_mode))
        else $error("result mode differs from the mode state");

    a_fault_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> (r_res.speed_fault == r_fault))
        else $error("result fault differs from the fault state");

    a_fnow_smo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv && r_mode != MODE_SMO) |=> !r_res.fault_now)
        else $error("overcurrent flagged outside SMO");

    a_flip_pol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> (!r_res.flip_angle || (r_pol && r_res.clear_id_sums)))
        else $error("angle flip without pi polarity");

endmodule
